// ===== sv/mmx_pkg.sv =====
// shared types and constants for the memory-to-memory execute unit
package mmx_pkg;
   localparam int MemWordsDefault = 256;
   localparam int WordW = 16;

   localparam logic [1:0] ModeExec  = 2'd0;
   localparam logic [1:0] ModeWrite = 2'd1;
   localparam logic [1:0] ModeRead  = 2'd2;
   localparam logic [1:0] ModeSetPc = 2'd3;

   localparam logic [1:0] StOk    = 2'd0;
   localparam logic [1:0] StDiv0  = 2'd1;
   localparam logic [1:0] StBadOp = 2'd2;
   localparam logic [1:0] StRange = 2'd3;

   localparam logic [3:0] OpAdd   = 4'd0;
   localparam logic [3:0] OpSub   = 4'd1;
   localparam logic [3:0] OpMul   = 4'd2;
   localparam logic [3:0] OpDiv   = 4'd3;
   localparam logic [3:0] OpBne   = 4'd4;
   localparam logic [3:0] OpSlt   = 4'd5;
   localparam logic [3:0] OpAddI  = 4'd6;
   localparam logic [3:0] OpSubI  = 4'd7;
   localparam logic [3:0] OpMulI  = 4'd8;
   localparam logic [3:0] OpDivI  = 4'd9;
   localparam logic [3:0] OpAddII = 4'd10;
   localparam logic [3:0] OpSubII = 4'd11;
   localparam logic [3:0] OpLoad  = 4'd12;
   localparam logic [3:0] OpStore = 4'd13;
   localparam logic [3:0] OpJback = 4'd14;

   // bit-serial unit operations
   typedef enum logic [1:0] {
      SerMul,
      SerDiv
   } ser_op_type;

   typedef struct packed {
      logic       start;
      ser_op_type op;
   } ser_ctl_type;
endpackage

// ===== sv/mmx_serial_unit.sv =====
// bit-serial shift-add multiplier and restoring divider, one bit per cycle
module mmx_serial_unit
   import mmx_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ser_ctl_type       ctl,
   input  logic [WordW-1:0]  opa,
   input  logic [WordW-1:0]  opb,
   output logic              done,
   output logic [WordW-1:0]  result
);
   localparam int CntW = $clog2(WordW + 1);

   logic             busy_ff, busy_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   ser_op_type       op_ff, op_in;
   logic [WordW-1:0] acc_ff, acc_in;   // product or remainder
   logic [WordW-1:0] sh_ff, sh_in;     // multiplier or dividend/quotient
   logic [WordW-1:0] b_ff, b_in;
   logic             done_ff, done_in;
   logic [WordW:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      b_in    = b_ff;
      done_in = 1'b0;
      trial   = '0;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         op_in   = ctl.op;
         acc_in  = '0;
         sh_in   = opa;
         b_in    = opb;
      end else if (busy_ff) begin
         if (op_ff == SerMul) begin
            // msb first: acc = acc*2 + (bit ? b : 0)
            acc_in = {acc_ff[WordW-2:0], 1'b0} + (sh_ff[WordW-1] ? b_ff : '0);
            sh_in  = {sh_ff[WordW-2:0], 1'b0};
         end else begin
            trial = {acc_ff, sh_ff[WordW-1]} - {1'b0, b_ff};
            if (!trial[WordW]) begin
               acc_in = trial[WordW-1:0];
               sh_in  = {sh_ff[WordW-2:0], 1'b1};
            end else begin
               acc_in = {acc_ff[WordW-2:0], sh_ff[WordW-1]};
               sh_in  = {sh_ff[WordW-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(WordW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= SerMul;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      b_ff   <= b_in;
   end

   assign done   = done_ff;
   assign result = (op_ff == SerMul) ? acc_ff : sh_ff;
endmodule

// ===== sv/mem_mem_isa_execute_unit.sv =====
// top level of the memory-to-memory instruction execute unit
//
// one request on req_ gives exactly one result on rsp_. mode 0 runs an
// instruction against the word store and program counter, mode 1 writes a
// word, mode 2 reads a word, mode 3 loads the program counter.
// the block works on one request at a time: req_tready is high while it is
// idle or while the only thing left is a result waiting in the output
// register. the result is registered; store reads go through a registered
// memory port, up to three dependent reads, and multiply and divide run
// through a bit-serial unit.
// reset clears the program counter and all control state; the store holds
// nothing defined until written. when the receiver stalls, the result stays
// in the output register and the block still takes the next request, which
// then waits in its final state until the register frees.
module mem_mem_isa_execute_unit
   import mmx_pkg::*;
#(
   parameter int MEM_WORDS = MemWordsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[1:0], instruction[17:2], address[25:18], data[41:26], zero fill
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pc[15:0], status[17:16], wrote[18], write_address[26:19],
   // write_value[42:27], read_data[58:43], zero fill
   output logic [63:0] rsp_tdata
);
   localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

   typedef enum logic [3:0] {
      SIdle, SRdA, SRdB, SRdC, SWaitC, SExec, SRdSum, SWaitSum, SSer, SDone
   } state_type;

   logic [WordW-1:0] mem [MEM_WORDS];

   state_type        state_ff;
   logic [1:0]       mode_ff;
   logic [15:0]      ins_ff;
   logic [7:0]       addr_ff;
   logic [15:0]      data_ff;
   logic [15:0]      pc_ff;
   logic [15:0]      ma_ff, mb_ff;
   logic [16:0]      sum_ff;
   logic [15:0]      rd_q;
   logic [AW-1:0]    rd_addr;
   logic             rd_en;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [15:0]      wr_val;

   logic             ovalid_ff;
   logic [63:0]      odata_ff;

   // result under construction
   logic [1:0]       r_status;
   logic             r_wrote;
   logic [16:0]      r_waddr;
   logic [15:0]      r_wval;
   logic [15:0]      r_rdata;
   logic [15:0]      r_pc;

   ser_ctl_type      ser_ctl;
   logic [15:0]      ser_a, ser_b, ser_res;
   logic             ser_done;

   logic [3:0] opc, oa, ob, oc;
   assign opc = ins_ff[15:12];
   assign oa  = ins_ff[11:8];
   assign ob  = ins_ff[7:4];
   assign oc  = ins_ff[3:0];

   logic req_fire, out_free;
   assign out_free   = !ovalid_ff || rsp_tready;
   assign req_tready = (state_ff == SIdle);
   assign req_fire   = req_tvalid && req_tready;

   mmx_serial_unit u_ser (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ser_ctl),
      .opa    (ser_a),
      .opb    (ser_b),
      .done   (ser_done),
      .result (ser_res)
   );

   // operand selection for serial unit, M[b] still on the read port in SExec
   always_comb begin
      ser_a = ma_ff;
      ser_b = rd_q;
      ser_ctl.start = (state_ff == SExec) && mode_ff == ModeExec &&
                      (opc == OpMul || opc == OpMulI ||
                       ((opc == OpDiv) && rd_q != '0) ||
                       ((opc == OpDivI) && ob != '0));
      ser_ctl.op = (opc == OpDiv || opc == OpDivI) ? SerDiv : SerMul;
      if (opc == OpMulI || opc == OpDivI) ser_b = {12'd0, ob};
   end

   // memory read address
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      case (state_ff)
         SRdA:   begin rd_en = 1'b1; rd_addr = AW'(oa); end
         SRdB:   begin rd_en = 1'b1; rd_addr = AW'(ob); end
         SRdC:   begin rd_en = 1'b1; rd_addr = AW'(oc); end
         SRdSum: begin rd_en = 1'b1; rd_addr = sum_ff[AW-1:0]; end
         SIdle:  begin rd_en = req_fire; rd_addr = AW'(req_tdata[25:18]); end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_q <= mem[rd_addr];
      if (wr_en) mem[wr_addr] <= wr_val;
   end

   // final result of the item, valid in SDone
   always_comb begin
      r_status = StOk;
      r_wrote  = 1'b0;
      r_waddr  = {13'd0, oc};
      r_wval   = '0;
      r_rdata  = '0;
      r_pc     = pc_ff;
      case (mode_ff)
         ModeWrite: begin
            if (32'(addr_ff) < MEM_WORDS) begin
               r_wrote = 1'b1; r_waddr = {9'd0, addr_ff}; r_wval = data_ff;
            end else r_status = StRange;
         end
         ModeRead: begin
            if (32'(addr_ff) < MEM_WORDS) r_rdata = rd_q;
            else r_status = StRange;
         end
         ModeSetPc: r_pc = data_ff;
         default: begin
            r_wrote = 1'b1;
            case (opc)
               OpAdd:   r_wval = ma_ff + mb_ff;
               OpSub:   r_wval = ma_ff - mb_ff;
               OpMul, OpMulI: r_wval = ser_res;
               OpDiv:   if (mb_ff == '0) r_status = StDiv0; else r_wval = ser_res;
               OpDivI:  if (ob == '0) r_status = StDiv0; else r_wval = ser_res;
               OpBne:   r_wrote = 1'b0;
               OpSlt:   r_wval = {15'd0, ma_ff < mb_ff};
               OpAddI:  r_wval = ma_ff + {12'd0, ob};
               OpSubI:  r_wval = ma_ff - {12'd0, ob};
               OpAddII: r_wval = {12'd0, oa} + {12'd0, ob};
               OpSubII: r_wval = {12'd0, oa} - {12'd0, ob};
               OpLoad:  if (32'(sum_ff) < MEM_WORDS) r_wval = rd_q;
                        else r_status = StRange;
               OpStore: if (32'(sum_ff) < MEM_WORDS) begin
                           r_waddr = sum_ff; r_wval = rd_q;
                        end else r_status = StRange;
               OpJback: r_wrote = 1'b0;
               default: r_status = StBadOp;
            endcase
            if (r_status != StOk) begin
               r_wrote = 1'b0;
            end else if (opc == OpBne) begin
               r_pc = pc_ff + ((ma_ff != mb_ff) ? {12'd0, oc} : 16'd1);
            end else if (opc == OpJback) begin
               r_pc = pc_ff - ({12'd0, oa} + {12'd0, ob} + {12'd0, oc});
            end else begin
               r_pc = pc_ff + 16'd1;
            end
         end
      endcase
      if (!r_wrote) begin
         r_waddr = '0;
         r_wval  = '0;
      end
   end

   assign wr_en   = (state_ff == SDone) && out_free && r_wrote;
   assign wr_addr = r_waddr[AW-1:0];
   assign wr_val  = r_wval;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= SIdle;
         pc_ff     <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         if (state_ff == SDone && out_free) ovalid_ff <= 1'b1;
         else if (rsp_tready) ovalid_ff <= 1'b0;
         case (state_ff)
            SIdle: if (req_fire) begin
               mode_ff <= req_tdata[1:0];
               ins_ff  <= req_tdata[17:2];
               addr_ff <= req_tdata[25:18];
               data_ff <= req_tdata[41:26];
               state_ff <= (req_tdata[1:0] == ModeExec) ? SRdA : SExec;
            end
            SRdA: state_ff <= SRdB;
            SRdB: begin
               ma_ff <= rd_q;
               state_ff <= (opc == OpStore) ? SRdC : SExec;
            end
            SRdC: begin
               mb_ff  <= rd_q;
               sum_ff <= {1'b0, ma_ff} + {1'b0, rd_q};
               state_ff <= SWaitC;
            end
            SWaitC: state_ff <= SDone;   // rd_q holds M[c]
            SExec: begin
               if (mode_ff == ModeExec) begin
                  mb_ff  <= rd_q;
                  sum_ff <= {1'b0, ma_ff} + {1'b0, rd_q};
               end
               if (mode_ff == ModeExec && opc == OpLoad) state_ff <= SRdSum;
               else if (ser_ctl.start) state_ff <= SSer;
               else state_ff <= SDone;
            end
            SRdSum: state_ff <= SWaitSum;
            SWaitSum: state_ff <= SDone;
            SSer: if (ser_done) state_ff <= SDone;
            SDone: if (out_free) begin
               odata_ff  <= {5'd0, r_rdata, r_wval, r_waddr[7:0], r_wrote, r_status, r_pc};
               pc_ff     <= r_pc;
               state_ff  <= SIdle;
            end
            default: state_ff <= SIdle;
         endcase
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
endmodule

// ===== sv/mmx_checker.sv =====
// port-level checker for the execute unit, bound to the top level
module mmx_checker
   import mmx_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [47:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped under stall");
   a_no_write_on_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17:16] != StOk |-> !rsp_tdata[18])
      else $error("write reported with fault");
   a_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[18] |-> rsp_tdata[42:19] == '0)
      else $error("write fields not cleared");
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result after reset");
endmodule

bind mem_mem_isa_execute_unit mmx_checker u_mmx_checker (.*);

// ===== bench/testbench.sv =====
// self-checking bench for the memory-to-memory execute unit
`timescale 1ns / 100ps

module testbench;
   import mmx_pkg::*;

   typedef struct packed {
      logic [15:0] data;
      logic [7:0]  address;
      logic [15:0] instruction;
      logic [1:0]  mode;
   } cmd_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic [15:0] write_value;
      logic [7:0]  write_address;
      logic        wrote;
      logic [1:0]  status;
      logic [15:0] pc;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;

   mem_mem_isa_execute_unit dut (.*);

   always #4 clock = ~clock;

   cmd_type     pending_cmds[$];
   outcome_type expected_outcomes[$];
   logic [15:0] words[256];
   bit          written[256];
   logic [15:0] prog_ctr;
   int  mismatches = 0;
   int  cycle = 0;
   bit  calm = 0;          // no random idling
   bit  sender_hold = 0;
   bit  stall_start = 0;
   bit  hold_off = 0;      // receiver held off
   bit  done = 0;

   // predict one request and update the model state
   function automatic outcome_type execute_cmd(cmd_type c);
      outcome_type r;
      logic [3:0] opc, a, b, k;
      logic [15:0] ma, mb, val, stp;
      logic [16:0] sum;
      logic [7:0] wa;
      bit wr;
      r = '0;
      wr = 0; val = 0; wa = 0; stp = 1;
      opc = c.instruction[15:12]; a = c.instruction[11:8];
      b = c.instruction[7:4]; k = c.instruction[3:0];
      ma = words[a]; mb = words[b];
      sum = {1'b0, ma} + {1'b0, mb};
      case (c.mode)
         ModeWrite: begin wr = 1; wa = c.address; val = c.data; end
         ModeRead: r.read_data = words[c.address];
         ModeSetPc: prog_ctr = c.data;
         default: begin
            wa = {4'd0, k};
            case (opc)
               OpAdd: begin val = ma + mb; wr = 1; end
               OpSub: begin val = ma - mb; wr = 1; end
               OpMul: begin val = ma * mb; wr = 1; end
               OpDiv: if (mb == 0) r.status = StDiv0;
                  else begin val = ma / mb; wr = 1; end
               OpBne: stp = (ma != mb) ? {12'd0, k} : 16'd1;
               OpSlt: begin val = (ma < mb) ? 16'd1 : 16'd0; wr = 1; end
               OpAddI: begin val = ma + b; wr = 1; end
               OpSubI: begin val = ma - b; wr = 1; end
               OpMulI: begin val = ma * b; wr = 1; end
               OpDivI: if (b == 0) r.status = StDiv0;
                  else begin val = ma / b; wr = 1; end
               OpAddII: begin val = 16'(a) + 16'(b); wr = 1; end
               OpSubII: begin val = 16'(a) - 16'(b); wr = 1; end
               OpLoad: if (sum >= 256) r.status = StRange;
                  else begin val = words[sum[7:0]]; wr = 1; end
               OpStore: if (sum >= 256) r.status = StRange;
                  else begin wa = sum[7:0]; val = words[k]; wr = 1; end
               OpJback: stp = 16'd0 - (16'(a) + 16'(b) + 16'(k));
               default: r.status = StBadOp;
            endcase
            if (r.status == StOk) prog_ctr = prog_ctr + stp;
            else wr = 0;
         end
      endcase
      if (wr) begin
         words[wa] = val; written[wa] = 1;
         r.wrote = 1; r.write_address = wa; r.write_value = val;
      end
      r.pc = prog_ctr;
      return r;
   endfunction

   function automatic cmd_type mk(logic [1:0] m, logic [15:0] ins,
                                  logic [7:0] ad, logic [15:0] d);
      cmd_type c;
      c.mode = m; c.instruction = ins; c.address = ad; c.data = d;
      return c;
   endfunction

   // tracking model used only to keep stimulus on written words
   logic [15:0] gen_words[256];
   bit          gen_written[256];

   function automatic bit gen_ok(cmd_type c);
      logic [3:0] opc, a, b, k;
      logic [16:0] sum;
      opc = c.instruction[15:12]; a = c.instruction[11:8];
      b = c.instruction[7:4]; k = c.instruction[3:0];
      if (c.mode == ModeRead) return gen_written[c.address];
      if (c.mode != ModeExec) return 1;
      if (opc inside {OpAdd, OpSub, OpMul, OpDiv, OpBne, OpSlt, OpLoad, OpStore})
         if (!gen_written[a] || !gen_written[b]) return 0;
      if (opc inside {OpAddI, OpSubI, OpMulI, OpDivI} && !gen_written[a]) return 0;
      if (opc == OpLoad || opc == OpStore) begin
         sum = {1'b0, gen_words[a]} + {1'b0, gen_words[b]};
         if (sum < 256 && opc == OpLoad && !gen_written[sum[7:0]]) return 0;
         if (sum < 256 && opc == OpStore && !gen_written[k]) return 0;
      end
      return 1;
   endfunction

   task automatic push(cmd_type c);
      logic [15:0] save_pc;
      logic [15:0] save_w[256];
      bit save_v[256];
      save_w = words; save_v = written; save_pc = prog_ctr;
      words = gen_words; written = gen_written;
      void'(execute_cmd(c));
      gen_words = words; gen_written = written;
      words = save_w; written = save_v; prog_ctr = save_pc;
      pending_cmds = {pending_cmds, c};
   endtask

   task automatic try_push(cmd_type c);
      if (gen_ok(c)) push(c);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_cmds.size() > 0 && !sender_hold &&
             (calm || $urandom_range(99) >= 11)) begin
            req_tdata <= {6'd0, pending_cmds.pop_front()};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // prediction at acceptance
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         expected_outcomes = {expected_outcomes, execute_cmd(cmd_type'(req_tdata[41:0]))};
   end

   // long receiver stall, counted here
   initial begin
      wait (stall_start);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (200) @(posedge clock);
      hold_off <= 1'b0;
   end

   // receiver readiness
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 11);
      end
   end

   // monitor
   always @(posedge clock) begin
      outcome_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = outcome_type'(rsp_tdata[58:0]);
         if (expected_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
         end else begin
            want = expected_outcomes.pop_front();
            if (got !== want || rsp_tdata[63:59] !== '0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: pc %h/%h st %0d/%0d wr %0d/%0d wa %h/%h wv %h/%h rd %h/%h",
                           want.pc, got.pc, want.status, got.status, want.wrote, got.wrote,
                           want.write_address, got.write_address, want.write_value,
                           got.write_value, want.read_data, got.read_data);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > 400000 && !done) begin
         $display("mem_mem_isa_execute_unit test failed");
         $finish;
      end
   end

   // sampled away from the rising edge so driver updates have settled
   task automatic wait_drained();
      while (pending_cmds.size() > 0 || req_tvalid || expected_outcomes.size() > 0)
         @(negedge clock);
   endtask

   task automatic random_cmds(int n);
      cmd_type c;
      int sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         if (sel < 8)
            c = mk(ModeWrite, 16'($urandom), 8'($urandom), 16'($urandom));
         else if (sel < 13)
            c = mk(ModeWrite, 16'($urandom), 8'($urandom_range(15)), 16'($urandom));
         else if (sel < 20)
            c = mk(ModeRead, 16'($urandom), 8'($urandom), 16'($urandom));
         else if (sel < 24)
            c = mk(ModeSetPc, 16'($urandom), 8'($urandom), 16'($urandom));
         else if (sel < 30)
            c = mk(ModeWrite, 16'($urandom), 8'($urandom_range(15)),
                   16'($urandom_range(120)));
         else
            c = mk(ModeExec, 16'($urandom), 8'($urandom), 16'($urandom));
         if (gen_ok(c)) push(c);
         else i--;
      end
   endtask

   initial begin
      prog_ctr = 0;
      for (int i = 0; i < 256; i++) begin
         written[i] = 0; gen_written[i] = 0; words[i] = 0; gen_words[i] = 0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: fill low words, then every opcode and the fault cases
      for (int i = 0; i < 16; i++)
         push(mk(ModeWrite, 16'(16'hffff * (i & 1)), i[7:0],
                 (i == 0) ? 16'd0 : (i == 1) ? 16'hffff : (i == 2) ? 16'd3 : 16'(i * 5)));
      push(mk(ModeWrite, '0, 8'd255, 16'hffff));
      push(mk(ModeRead, '0, 8'd255, 16'h0));
      push(mk(ModeSetPc, 16'hffff, 8'hff, 16'hfffe));
      for (int op = 0; op < 16; op++)
         try_push(mk(ModeExec, {op[3:0], 4'd1, 4'd2, 4'd7}, 8'($urandom),
                     16'($urandom)));
      try_push(mk(ModeExec, {OpDiv, 4'd1, 4'd0, 4'd9}, '0, '0));     // divide by zero
      try_push(mk(ModeExec, {OpDivI, 4'd1, 4'd0, 4'd9}, '0, '0));
      try_push(mk(ModeExec, {OpLoad, 4'd1, 4'd1, 4'd9}, '0, '0));    // offset past store
      try_push(mk(ModeExec, {OpStore, 4'd0, 4'd2, 4'd15}, '0, '0));
      try_push(mk(ModeExec, {OpJback, 4'd15, 4'd15, 4'd15}, '0, '0));
      try_push(mk(ModeExec, {OpBne, 4'd0, 4'd0, 4'd5}, '0, '0));
      wait_drained();

      // receiver holds off while the sender keeps offering
      calm = 1;
      random_cmds(40);
      stall_start = 1;
      wait_drained();
      calm = 0;

      random_cmds(300);
      wait_drained();
      sender_hold = 1;   // sender pauses while the new commands queue up
      random_cmds(20);
      repeat (30) @(posedge clock);
      sender_hold = 0;
      calm = 1;
      random_cmds(150);
      wait_drained();
      calm = 0;
      random_cmds(200);
      wait_drained();
      repeat (40) @(posedge clock);
      done = 1;
      if (mismatches == 0 && expected_outcomes.size() == 0)
         $display("mem_mem_isa_execute_unit test passed");
      else
         $display("mem_mem_isa_execute_unit test failed");
      $finish;
   end
endmodule
